@@ rtl/u8s_pkg.sv @@
// Shared types and constants for the UTF-8 stream sanitizer.
package u8s_pkg;

  localparam int unsigned JOB_SLOTS           = 4;
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

  localparam logic [7:0] QMARK = 8'h3F;
  localparam logic [7:0] SPACE = 8'h20;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_last;
  } out_item_t;

  // Result bytes caused by one request, oldest in slot 0.
  typedef struct packed {
    logic [JOB_SLOTS-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ rtl/u8s_front.sv @@
// Front part: accepts requests, tracks the pending sequence, builds result jobs.
module u8s_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  u8s_pkg::in_item_t   byte_data,
  input  u8s_pkg::q_status_t  q_status,
  output logic                push,
  output u8s_pkg::job_t       push_job
);

  logic [1:0]      held;
  logic [2:0]      needed;
  logic [2:0][7:0] held_bytes;

  logic [7:0]      b;
  logic            last;
  logic            accept;
  logic            cont;
  logic            pending;
  logic            complete;
  logic [1:0]      hc;
  logic [2:0]      nt;
  logic [2:0]      n;
  logic [2:0]      idx;
  logic [3:0][7:0] e;
  logic            wr_en;
  logic [1:0]      wr_idx;

  assign b          = byte_data.in_byte;
  assign last       = byte_data.in_last;
  assign byte_ready = !q_status.full;
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    cont     = (b[7:6] == 2'b10);
    pending  = (needed != 3'd0) && (held != 2'd0);
    complete = pending && cont && (({1'b0, held} + 3'd1) >= needed);
    e        = '0;
    n        = '0;
    idx      = '0;
    hc       = held;
    nt       = needed;
    wr_en    = 1'b0;
    wr_idx   = held;
    if (complete) begin
      // release the whole sequence unchanged
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < held) e[k] = held_bytes[k];
      end
      e[held] = b;
      n  = {1'b0, held} + 3'd1;
      hc = 2'd0;
      nt = 3'd0;
    end else if (pending && cont) begin
      wr_en = 1'b1;
      hc    = held + 2'd1;
    end else begin
      // replace any broken sequence with question marks, then treat the byte as fresh input
      if (pending) begin
        for (int k = 0; k < 3; k++) begin
          if (2'(k) < held) e[k] = u8s_pkg::QMARK;
        end
        n = {1'b0, held};
      end
      hc = 2'd0;
      nt = 3'd0;
      if (!b[7]) begin
        if (b inside {[8'h20:8'h7E], 8'h09, 8'h0A, 8'h0D}) e[n[1:0]] = b;
        else e[n[1:0]] = u8s_pkg::SPACE;
        n = n + 3'd1;
      end else if (b[7:5] == 3'b110) begin
        wr_en = 1'b1; wr_idx = 2'd0; hc = 2'd1; nt = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
        wr_en = 1'b1; wr_idx = 2'd0; hc = 2'd1; nt = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
        wr_en = 1'b1; wr_idx = 2'd0; hc = 2'd1; nt = 3'd4;
      end else begin
        e[n[1:0]] = u8s_pkg::QMARK;
        n = n + 3'd1;
      end
    end
    if (last) begin
      // flush what is still held at end of string
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < hc) begin
          idx = n + 3'(k);
          e[idx[1:0]] = u8s_pkg::QMARK;
        end
      end
      n  = n + {1'b0, hc};
      hc = 2'd0;
      nt = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held   <= 2'd0;
      needed <= 3'd0;
    end else if (accept) begin
      held   <= hc;
      needed <= nt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) held_bytes[wr_idx] <= b;
  end

  assign push           = accept && (n != 3'd0);
  assign push_job.bytes = e;
  assign push_job.count = n;
  assign push_job.last  = last;

endmodule

@@ rtl/u8s_queue.sv @@
// Short job queue between the front and back parts.
module u8s_queue #(
  parameter int unsigned DEPTH = u8s_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  u8s_pkg::job_t      push_job,
  input  logic               pop,
  output u8s_pkg::job_t      head_job,
  output u8s_pkg::q_status_t q_status
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  u8s_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] cnt;

  assign q_status.full  = (cnt == CW'(DEPTH));
  assign q_status.empty = (cnt == '0);
  assign head_job       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

endmodule

@@ rtl/u8s_back.sv @@
// Back part: serializes each job into bytes, one per cycle unless stalled.
module u8s_back (
  input  logic               clk,
  input  logic               rst,
  input  u8s_pkg::job_t      head_job,
  input  u8s_pkg::q_status_t q_status,
  output logic               pop,
  output logic               clean_valid,
  input  logic               clean_ready,
  output u8s_pkg::out_item_t clean_data
);

  u8s_pkg::job_t cur;
  logic          busy;
  logic [1:0]    pos;
  logic          final_one;
  logic          done;

  assign final_one = (({1'b0, pos} + 3'd1) == cur.count);
  assign done      = clean_valid && clean_ready && final_one;
  assign pop       = !q_status.empty && (!busy || done);

  assign clean_valid            = busy;
  assign clean_data.out_byte    = cur.bytes[pos];
  assign clean_data.run_last    = final_one;
  assign clean_data.stream_last = final_one && cur.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      pos  <= 2'd0;
    end else if (done) begin
      busy <= 1'b0;
      pos  <= 2'd0;
    end else if (clean_valid && clean_ready) begin
      pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= head_job;
  end

endmodule

@@ rtl/utf8_stream_sanitizer_top.sv @@
// Top level of the UTF-8 stream sanitizer: front, job queue and back.
// Path: a result byte passes from the request that completes it into a queue slot,
//   written at the accepting edge, then into the back job register before it is
//   presented; it waits longer while the queue or the output stalls.
// Throughput: one input request per cycle while the queue has room; each yields
//   0 to 4 bytes, sent one per cycle unless stalled; bursts drain via the queue.
// Reset: synchronous, active high; clears sequence state, queue pointers and
//   the output valid; held sequence bytes, queue slots and the output byte
//   register are not cleared.
module utf8_stream_sanitizer_top #(
  parameter int unsigned QUEUE_DEPTH = u8s_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  u8s_pkg::in_item_t  byte_data,
  output logic               clean_valid,
  input  logic               clean_ready,
  output u8s_pkg::out_item_t clean_data
);

  // Jobs travel from the front into the queue; the back pulls them out.
  logic               push;
  u8s_pkg::job_t      push_job;
  logic               pop;
  u8s_pkg::job_t      head_job;
  u8s_pkg::q_status_t q_status;

  // Classify each byte and build the batch of result bytes it releases.
  u8s_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .q_status   (q_status),
    .push       (push),
    .push_job   (push_job)
  );

  // Hold batches so the input side keeps moving while the output stalls.
  u8s_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_status (q_status)
  );

  // Send each batch out byte by byte, marking the last of each request.
  u8s_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .q_status    (q_status),
    .pop         (pop),
    .clean_valid (clean_valid),
    .clean_ready (clean_ready),
    .clean_data  (clean_data)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("job popped from an empty queue");

  a_job_count: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_job.count != 3'd0) && (push_job.count <= 3'd4))
    else $error("job byte count out of range");

  a_stream_end: assert property (@(posedge clk) disable iff (rst)
    (clean_valid && clean_data.stream_last) |-> clean_data.run_last)
    else $error("end of string not on the last byte of a request");
`endif

endmodule
